[rtl/core/sgd_pkg.sv]
`default_nettype none
package sgd_pkg;

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SENSOR   = 2'd0;
  localparam mode_t MODE_CYLINDER = 2'd1;
  localparam mode_t MODE_TWIN     = 2'd2;
  localparam mode_t MODE_UNUSED   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_RANGE     = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_NO_OTHERS = 2'd3;

  // Width used when comparing sensor indices, counts and group members.
  localparam int CMP_W = 8;

endpackage
`default_nettype wire

[rtl/core/sensor_group_deviation.sv]
`default_nettype none
// Sensor group deviation. A write word (op 0) stores one sensor reading and
// its valid flag and gives no result. A query word (op 1) walks the active
// sensors through the single read port of the reading RAM, one per cycle,
// then divides the group sum and the sum of the other valid readings by their
// counts in one shared bit-serial divider. Each division loads the divider and
// then yields one quotient bit per cycle. The walk covers the active sensor
// count, capped at MAX_SENSORS. A query that finds an empty group or no other
// valid readings stops after the walk without dividing, and a query whose
// target is out of range answers on the next cycle without raising busy. Each
// result appears on deviation and status for exactly one cycle with done high,
// in the same cycle that busy falls; the receiver cannot stall it and must
// take it then.
module sensor_group_deviation #(
  parameter int MAX_SENSORS   = 32,
  parameter int READING_WIDTH = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            op,
  input  wire logic [4:0]                      sensor_index,
  input  wire logic signed [READING_WIDTH-1:0] reading,
  input  wire logic                            reading_valid,
  input  wire sgd_pkg::mode_t                  mode,
  input  wire logic [4:0]                      target,
  input  wire logic                            cfg_we,
  input  wire logic [5:0]                      cfg_data,
  output logic                                 done,
  output logic signed [READING_WIDTH-1:0]      deviation,
  output sgd_pkg::status_t                     status
);

  import sgd_pkg::*;

  localparam int IDX_W = $clog2(MAX_SENSORS);
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam int SUM_W = READING_WIDTH + CNT_W;
  localparam int RW    = READING_WIDTH;

  typedef enum logic [2:0] {
    IDLE, WALK, DRAIN, CHECK, DIV_G, DIV_O
  } state_t;

  state_t state;

  logic [5:0]             active_sensor_count;
  logic [MAX_SENSORS-1:0] written;
  logic [MAX_SENSORS-1:0] valid_store;

  logic                   accept;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [CMP_W-1:0]       max8;
  logic [CMP_W-1:0]       cnt8;
  logic [CMP_W-1:0]       eff8;
  logic [CMP_W-1:0]       tgt8;
  logic [CMP_W-1:0]       top8;
  logic                   in_range;

  mode_t                  q_mode;
  logic [4:0]             q_tgt;
  logic [CNT_W-1:0]       cnt_eff;
  logic [CNT_W-1:0]       j;
  logic [CNT_W-1:0]       j_p;
  logic                   pv;
  logic [RW-1:0]          rd_data;

  logic signed [SUM_W-1:0] gsum;
  logic signed [SUM_W-1:0] osum;
  logic [2:0]              gn;
  logic [CNT_W-1:0]        on_cnt;

  logic [CMP_W-1:0]        jp8;
  logic [CMP_W-1:0]        half8;
  logic [CMP_W-1:0]        qt8;
  logic                    member;
  logic                    entry_valid;
  logic signed [RW-1:0]    entry;
  logic signed [SUM_W-1:0] acc_in;
  logic signed [SUM_W-1:0] acc_sum;

  logic                    div_start;
  logic signed [SUM_W-1:0] div_num;
  logic [CNT_W-1:0]        div_den;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_q;
  logic signed [RW-1:0]    gval;
  logic signed [RW-1:0]    oval;
  logic signed [RW:0]      diff;
  logic signed [RW-1:0]    diff_sat;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  // Count and index checks, done in a common 8-bit domain.
  assign max8    = CMP_W'(MAX_SENSORS);
  assign cnt8    = CMP_W'(active_sensor_count);
  assign eff8    = (cnt8 > max8) ? max8 : cnt8;
  assign tgt8    = CMP_W'(target);

  always_comb begin
    case (mode)
      MODE_SENSOR:   top8 = tgt8;
      MODE_CYLINDER: top8 = (tgt8 << 1) + CMP_W'(1);
      MODE_TWIN:     top8 = (tgt8 << 1) + CMP_W'(3);
      default:       top8 = '1;
    endcase
  end

  assign in_range = (mode != MODE_UNUSED) && (top8 < eff8);

  assign wr_en   = accept && (op == OP_WRITE) && (CMP_W'(sensor_index) < max8);
  assign wr_addr = IDX_W'(sensor_index);

  sgd_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_SENSORS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(reading),
    .raddr(j[IDX_W-1:0]),
    .rdata(rd_data)
  );

  // Group membership of the entry whose read data arrives this cycle.
  assign jp8    = CMP_W'(j_p);
  assign half8  = jp8 >> 1;
  assign qt8    = CMP_W'(q_tgt);

  always_comb begin
    case (q_mode)
      MODE_SENSOR:   member = (jp8 == qt8);
      MODE_CYLINDER: member = (half8 == qt8);
      MODE_TWIN:     member = (half8 == qt8) || (half8 == qt8 + CMP_W'(1));
      default:       member = 1'b0;
    endcase
  end

  // An entry never written reads as zero.
  assign entry       = written[j_p[IDX_W-1:0]] ? $signed(rd_data) : '0;
  assign entry_valid = valid_store[j_p[IDX_W-1:0]];
  assign acc_in      = member ? gsum : osum;
  assign acc_sum     = acc_in + SUM_W'(entry);

  assign div_start = ((state == CHECK) && !((q_mode != MODE_SENSOR) && (gn == '0))
                      && (on_cnt != '0)) || ((state == DIV_G) && div_done);
  assign div_num   = (state == CHECK) ? gsum : osum;
  assign div_den   = (state == CHECK) ? CNT_W'(gn) : on_cnt;

  sgd_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  assign oval = div_q[RW-1:0];
  assign diff = {gval[RW-1], gval} - {oval[RW-1], oval};

  always_comb begin
    if (diff[RW] != diff[RW-1]) begin
      diff_sat = diff[RW] ? $signed({1'b1, {(RW-1){1'b0}}}) : $signed({1'b0, {(RW-1){1'b1}}});
    end else begin
      diff_sat = diff[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sensor_count <= 6'd16;
      written             <= '0;
      valid_store         <= '0;
    end else begin
      if (cfg_we) begin
        active_sensor_count <= cfg_data;
      end
      if (wr_en) begin
        written[wr_addr]     <= 1'b1;
        valid_store[wr_addr] <= reading_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      pv        <= 1'b0;
      status    <= ST_OK;
      deviation <= '0;
    end else begin
      done <= 1'b0;
      pv   <= (state == WALK);
      j_p  <= j;
      if (pv) begin
        if (member && (q_mode == MODE_SENSOR)) begin
          gsum <= SUM_W'(entry);
          gn   <= 3'd1;
        end else if (member && entry_valid) begin
          gsum <= acc_sum;
          gn   <= gn + 1'b1;
        end else if (!member && entry_valid) begin
          osum   <= acc_sum;
          on_cnt <= on_cnt + 1'b1;
        end
      end
      case (state)
        IDLE: begin
          if (accept && (op == OP_QUERY)) begin
            q_mode  <= mode;
            q_tgt   <= target;
            cnt_eff <= eff8[CNT_W-1:0];
            j       <= '0;
            gsum    <= '0;
            osum    <= '0;
            gn      <= '0;
            on_cnt  <= '0;
            if (in_range) begin
              state <= WALK;
            end else begin
              done      <= 1'b1;
              status    <= ST_RANGE;
              deviation <= '0;
            end
          end
        end
        WALK: begin
          j <= j + 1'b1;
          if (j == cnt_eff - 1'b1) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= CHECK;
        end
        CHECK: begin
          if ((q_mode != MODE_SENSOR) && (gn == '0)) begin
            done      <= 1'b1;
            status    <= ST_EMPTY;
            deviation <= '0;
            state     <= IDLE;
          end else if (on_cnt == '0) begin
            done      <= 1'b1;
            status    <= ST_NO_OTHERS;
            deviation <= '0;
            state     <= IDLE;
          end else begin
            state <= DIV_G;
          end
        end
        DIV_G: begin
          if (div_done) begin
            gval  <= div_q[RW-1:0];
            state <= DIV_O;
          end
        end
        DIV_O: begin
          if (div_done) begin
            done      <= 1'b1;
            status    <= ST_OK;
            deviation <= diff_sat;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A failed query always carries a zero deviation.
  assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (deviation == '0))
    else $error("failed query with nonzero deviation");

  // Read data is only consumed in the cycle after a walk step.
  assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == WALK) || (state == DRAIN))
    else $error("entry processed outside the sensor walk");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == DIV_G) || (state == DIV_O))
    else $error("divider result with no one waiting");

  // An accepted query either answers at once or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_QUERY) |=> busy || done)
    else $error("query dropped");

  // No store write can slip in during a query.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("store written while busy");

endmodule
`default_nettype wire

[rtl/core/sgd_ram.sv]
`default_nettype none
module sgd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/sgd_div.sv]
`default_nettype none
module sgd_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic       [DEN_W-1:0]  den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic             neg;
  logic [CNT_W-1:0] steps;
  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign mag     = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign shifted = {rem, q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign quo     = neg ? $signed(-q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q     <= mag;
        rem   <= '0;
        dvs   <= den;
        neg   <= num[NUM_W-1];
        steps <= CNT_W'(NUM_W);
      end else if (steps != '0) begin
        if (fits) begin
          rem <= DEN_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DEN_W-1:0];
        end
        q     <= {q[NUM_W-2:0], fits};
        steps <= steps - 1'b1;
        done  <= (steps == CNT_W'(1));
      end
    end
  end

endmodule
`default_nettype wire
